@@ design/wth_pkg.sv @@
// Shared types and constants of the word table with double hashing.
package wth_pkg;

    localparam int KEY_W    = 20;
    localparam int KEY_MULT = 26;
    localparam int DOC_W    = 4;
    localparam int OUT_W    = 10;
    localparam int BMP_W    = 16;

    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HASH,
        BK_READ,
        BK_CHECK
    } t_back_state;

endpackage

@@ design/word_table_double_hashing.sv @@
// Word table with double hashing, top level.
// Characters are taken one per cycle unless the word queue is full or the table is being
// cleared; the word in progress is buffered and hashed into a running key. Each
// last-character word is queued for the table engine, which accepts it, reduces the key
// modulo the table size and its predecessor (reciprocal multiply, multiply-subtract and
// final correction), then probes (one slot memory read, one full-word compare per probe),
// up to TABLE_SLOTS probes for a full table or a miss. A word longer than MAX_WORD_LEN
// gets ST_TOO_LONG without hashing. After reset the slot memory is swept empty, one slot
// per cycle; no character is accepted while the sweep runs.
module word_table_double_hashing import wth_pkg::*; #(
    parameter int TABLE_SLOTS  = 1021,
    parameter int MAX_WORD_LEN = 16,
    parameter int MAX_DOCS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // letter[7:0], doc_index[11:8], zero[15:12]
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // slot[9:0], probe_count[19:10], doc_bits[35:20], zero
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);
    localparam int JOB_W = 1 + DOC_W + LEN_W + KEY_W + 8 * MAX_WORD_LEN;

    logic             clearing;
    logic             f_valid, f_ready, q_valid, q_ready;
    logic [JOB_W-1:0] f_job, q_job;
    t_status          status;
    logic [OUT_W-1:0] slot, probes;
    logic [BMP_W-1:0] docs;

    wth_front #(.MAX_WORD_LEN(MAX_WORD_LEN), .LEN_W(LEN_W), .JOB_W(JOB_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_hold(clearing),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_letter(s_axis_tdata[7:0]),
        .i_last(s_axis_tlast), .i_doc(s_axis_tdata[11:8]),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    wth_fifo #(.W(JOB_W)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_job)
    );

    wth_back #(
        .TABLE_SLOTS(TABLE_SLOTS), .MAX_WORD_LEN(MAX_WORD_LEN), .MAX_DOCS(MAX_DOCS),
        .LEN_W(LEN_W), .JOB_W(JOB_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .o_clearing(clearing),
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_status(status), .o_slot(slot), .o_probes(probes), .o_docs(docs)
    );

    assign m_axis_tdata = {4'b0, docs, probes, slot};
    assign m_axis_tuser = status;

endmodule

@@ design/wth_front.sv @@
// Character intake: case folding, word buffer and running key.
module wth_front import wth_pkg::*; #(
    parameter int MAX_WORD_LEN = 16,
    parameter int LEN_W        = 5,
    parameter int JOB_W        = 158
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hold,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_func,
    input  logic [7:0]       i_letter,
    input  logic             i_last,
    input  logic [DOC_W-1:0] i_doc,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output logic [JOB_W-1:0] o_job
);
    localparam int IDX_W = $clog2(MAX_WORD_LEN);

    logic [7:0]              r_buf [MAX_WORD_LEN];
    logic [LEN_W-1:0]        r_len, n_len;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [7:0]              c;
    logic signed [8:0]       dif;
    logic [9:0]              w;
    logic signed [KEY_W-1:0] dif_x, w_x, prod;
    logic                    take, store;
    logic [8*MAX_WORD_LEN-1:0] chars;

    assign o_ready = !i_hold && i_job_ready;
    assign take    = i_valid && o_ready;
    assign store   = r_len < LEN_W'(MAX_WORD_LEN);

    always_comb begin
        c = i_letter;
        if (i_letter >= CHAR_UC_A && i_letter <= CHAR_UC_Z) begin
            c = i_letter + (CHAR_LC_A - CHAR_UC_A);
        end
        dif   = $signed({1'b0, c}) - $signed({1'b0, CHAR_LC_A});
        w     = 10'(KEY_MULT * int'(r_len));
        dif_x = KEY_W'(dif);
        w_x   = $signed(KEY_W'(w));
        prod  = dif_x * w_x;
        if (store) begin
            n_len = r_len + 1'b1;
            n_key = r_key + KEY_W'(prod);
        end else begin
            n_len = LEN_W'(MAX_WORD_LEN + 1);
            n_key = r_key;
        end
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            chars[8*k +: 8] = (store && r_len[IDX_W-1:0] == IDX_W'(k)) ? c : r_buf[k];
        end
    end

    assign o_job_valid = i_valid && !i_hold && i_last;
    assign o_job       = {chars, n_key, n_len, i_doc, i_func};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_key <= '0;
        end else if (take) begin
            r_len <= i_last ? '0 : n_len;
            r_key <= i_last ? '0 : n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && store) begin
            r_buf[r_len[IDX_W-1:0]] <= c;
        end
    end

endmodule

@@ design/wth_fifo.sv @@
// Two-entry word queue between intake and table engine.
module wth_fifo #(
    parameter int W = 158
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

@@ design/wth_back.sv @@
// Table engine: hashing, probe walk, slot memory and result register.
module wth_back import wth_pkg::*; #(
    parameter int TABLE_SLOTS  = 1021,
    parameter int MAX_WORD_LEN = 16,
    parameter int MAX_DOCS     = 16,
    parameter int LEN_W        = 5,
    parameter int JOB_W        = 158
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_clearing,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_status          o_status,
    output logic [OUT_W-1:0] o_slot,
    output logic [OUT_W-1:0] o_probes,
    output logic [BMP_W-1:0] o_docs
);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int PC_W   = $clog2(TABLE_SLOTS + 1);
    localparam int CH_W   = 8 * MAX_WORD_LEN;
    localparam int ROW_W  = 1 + LEN_W + MAX_DOCS + CH_W;
    localparam int U_W    = KEY_W + 1;
    localparam int P_W    = 2 * U_W;
    localparam int OFFS_A = TABLE_SLOTS * ((524288 + TABLE_SLOTS - 1) / TABLE_SLOTS);
    localparam int OFFS_B = (TABLE_SLOTS - 1) * ((524288 + TABLE_SLOTS - 2) / (TABLE_SLOTS - 1));
    localparam logic [U_W-1:0] RCP_A = U_W'((longint'(1) << U_W) / TABLE_SLOTS);
    localparam logic [U_W-1:0] RCP_B = U_W'((longint'(1) << U_W) / (TABLE_SLOTS - 1));

    t_back_state r_state, n_state;

    logic [ROW_W-1:0]  mem [TABLE_SLOTS];
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_clr;
    logic              r_func;
    logic [DOC_W-1:0]  r_doc;
    logic [LEN_W-1:0]  r_len;
    logic [CH_W-1:0]   r_chars;
    logic [U_W-1:0]    r_u, r_v, nu, nv, fa, fb;
    logic [P_W-1:0]    r_pa, r_pb, pa, pb;
    logic [4:0]        r_step;
    logic [SLOT_W-1:0] r_addr, r_h2;
    logic [SLOT_W:0]   addr_sum;
    logic [PC_W-1:0]   r_pc;

    logic              r_out_valid;
    t_status           r_status;
    logic [OUT_W-1:0]  r_slot, r_probes;
    logic [BMP_W-1:0]  r_docs;

    logic                row_used, chars_eq, match, hit, last_probe, pop, too_long, we;
    logic [LEN_W-1:0]    row_len;
    logic [MAX_DOCS-1:0] row_docs, new_docs;
    logic [CH_W-1:0]     row_chars;
    logic [ROW_W-1:0]    wdata;
    logic [SLOT_W-1:0]   waddr;
    logic signed [U_W:0] ka, kb;
    logic [KEY_W-1:0]    j_key;
    logic [LEN_W-1:0]    j_len;
    logic [SLOT_W+OUT_W-1:0]     slot_x;
    logic [PC_W+OUT_W-1:0]       pc_x;
    logic [MAX_DOCS+BMP_W-1:0]   docs_hit_x;

    assign j_key    = i_job[1+DOC_W+LEN_W +: KEY_W];
    assign j_len    = i_job[1+DOC_W +: LEN_W];
    assign too_long = j_len > LEN_W'(MAX_WORD_LEN);
    assign ka = $signed({j_key[KEY_W-1], j_key}) + (U_W+1)'(OFFS_A);
    assign kb = $signed({j_key[KEY_W-1], j_key}) + (U_W+1)'(OFFS_B);

    assign row_used  = r_row[0];
    assign row_len   = r_row[1 +: LEN_W];
    assign row_docs  = r_row[1+LEN_W +: MAX_DOCS];
    assign row_chars = r_row[1+LEN_W+MAX_DOCS +: CH_W];

    always_comb begin
        chars_eq = 1'b1;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (k < int'(r_len) && row_chars[8*k +: 8] != r_chars[8*k +: 8]) chars_eq = 1'b0;
        end
        match = row_used && row_len == r_len && chars_eq;
        hit   = r_func ? match : (!row_used || match);
        for (int b = 0; b < MAX_DOCS; b++) begin
            new_docs[b] = (row_used && row_docs[b]) || (32'(r_doc) == b);
        end
        pa = P_W'(r_u) * P_W'(RCP_A);
        pb = P_W'(r_v) * P_W'(RCP_B);
        nu = r_u - r_pa[P_W-1 -: U_W] * U_W'(TABLE_SLOTS);
        nv = r_v - r_pb[P_W-1 -: U_W] * U_W'(TABLE_SLOTS - 1);
        fa = (r_u >= U_W'(TABLE_SLOTS)) ? r_u - U_W'(TABLE_SLOTS) : r_u;
        fb = (r_v >= U_W'(TABLE_SLOTS - 1)) ? r_v - U_W'(TABLE_SLOTS - 1) : r_v;
        addr_sum   = {1'b0, r_addr} + {1'b0, r_h2};
        last_probe = r_pc == PC_W'(TABLE_SLOTS - 1);
        slot_x     = {{OUT_W{1'b0}}, r_addr};
        pc_x       = {{OUT_W{1'b0}}, r_pc + 1'b1};
        docs_hit_x = {{BMP_W{1'b0}}, (r_func ? row_docs : new_docs)};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) n_state = BK_IDLE;
            BK_IDLE:  if (pop && !too_long) n_state = BK_HASH;
            BK_HASH:  if (r_step == 5'd0) n_state = BK_READ;
            BK_READ:  n_state = BK_CHECK;
            BK_CHECK: n_state = (hit || last_probe) ? BK_IDLE : BK_READ;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_clearing  = r_state == BK_CLEAR;
        o_job_ready = r_state == BK_IDLE && !r_out_valid;
        pop         = i_job_valid && o_job_ready;
        we          = 1'b0;
        waddr       = r_addr;
        wdata       = {r_chars, new_docs, r_len, 1'b1};
        unique case (r_state)
            BK_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            BK_CHECK: we = hit && !r_func;
            default:  we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end else if ((pop && too_long) || (r_state == BK_CHECK && (hit || last_probe))) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (r_state == BK_READ) r_row <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (pop) begin
                    r_func   <= i_job[0];
                    r_doc    <= i_job[1 +: DOC_W];
                    r_len    <= j_len;
                    r_chars  <= i_job[JOB_W-1 -: CH_W];
                    r_u      <= ka[U_W-1:0];
                    r_v      <= kb[U_W-1:0];
                    r_step   <= 5'd2;
                    r_pc     <= '0;
                    r_status <= ST_TOO_LONG;
                    r_slot   <= '0;
                    r_probes <= '0;
                    r_docs   <= '0;
                end
            end
            BK_HASH: begin
                r_step <= r_step - 1'b1;
                if (r_step == 5'd2) begin
                    r_pa <= pa;
                    r_pb <= pb;
                end else if (r_step == 5'd1) begin
                    r_u <= nu;
                    r_v <= nv;
                end else begin
                    r_addr <= fa[SLOT_W-1:0];
                    r_h2   <= fb[SLOT_W-1:0] + 1'b1;
                end
            end
            BK_CHECK: begin
                if (hit) begin
                    r_status <= r_func ? ST_FOUND : (row_used ? ST_ADDED : ST_NEW);
                    r_slot   <= slot_x[OUT_W-1:0];
                    r_probes <= pc_x[OUT_W-1:0];
                    r_docs   <= docs_hit_x[BMP_W-1:0];
                end else if (last_probe) begin
                    r_status <= r_func ? ST_NOT_FOUND : ST_FULL;
                    r_slot   <= '0;
                    r_probes <= pc_x[OUT_W-1:0];
                    r_docs   <= '0;
                end else begin
                    r_pc   <= r_pc + 1'b1;
                    r_addr <= (addr_sum >= (SLOT_W+1)'(TABLE_SLOTS))
                              ? SLOT_W'(addr_sum - (SLOT_W+1)'(TABLE_SLOTS))
                              : addr_sum[SLOT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_probes    = r_probes;
    assign o_docs      = r_docs;

    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CLEAR |-> !r_out_valid) else $error("result during clearing pass");
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CHECK |-> r_addr < SLOT_W'(TABLE_SLOTS)) else $error("probe address out of table");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_CHECK |-> r_pc < PC_W'(TABLE_SLOTS)) else $error("probe count beyond table size");
    a_check_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CHECK && hit) |=> r_out_valid) else $error("hit without result");

endmodule
